// ===== src/knt_pkg.sv =====
// Package for the k-nomial tree neighbour finder.
// Holds field widths, register indexes, result codes, the controller state type
// and the command and status bundles between controller and datapath. No dependencies.
`default_nettype none

package knt_pkg;

    // Default sizes handed to the top level
    localparam int MAX_MEMBERS_DEF = 1024;
    localparam int MAX_DEGREE_DEF  = 16;

    // Fixed field widths
    localparam int IDX_W      = 10;
    localparam int COUNT_W    = 11;
    localparam int ROOT_W     = 10;
    localparam int DEG_W      = 5;
    localparam int METHOD_W   = 3;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MEMBER_COUNT = 3'd0,
        REG_ROOT_INDEX   = 3'd1,
        REG_DEGREE       = 3'd2,
        REG_DIRECTION    = 3'd3,
        REG_AGGREGATE    = 3'd4,
        REG_BROADCAST    = 3'd5
    } t_reg_idx;

    // Phase method codes
    localparam logic [METHOD_W-1:0] METH_REDUCE_WP    = 3'd0;
    localparam logic [METHOD_W-1:0] METH_REDUCE_TERM  = 3'd1;
    localparam logic [METHOD_W-1:0] METH_GATHER_WP    = 3'd2;
    localparam logic [METHOD_W-1:0] METH_RECV_TERM    = 3'd3;
    localparam logic [METHOD_W-1:0] METH_SEND_TERM    = 3'd4;
    localparam logic [METHOD_W-1:0] METH_BCAST_WP     = 3'd5;
    localparam logic [METHOD_W-1:0] METH_SCATTER_WP   = 3'd6;
    localparam logic [METHOD_W-1:0] METH_SCATTER_TERM = 3'd7;

    // Result status codes
    localparam logic [STATUS_W-1:0] STS_PEER      = 2'd0;
    localparam logic [STATUS_W-1:0] STS_NO_PEERS  = 2'd1;
    localparam logic [STATUS_W-1:0] STS_BAD_RANGE = 2'd2;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_POW,
        ST_DIG,
        ST_SETUP,
        ST_ROUTE,
        ST_LVL_MUL,
        ST_K_INIT,
        ST_CHILD,
        ST_PARENT,
        ST_STATUS
    } t_knt_state;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic pow_step;
        logic dig_step;
        logic setup;
        logic lvl_mul;
        logic k_init;
        logic k_step;
        logic lvl_next;
        logic emit_child;
        logic emit_par;
        logic emit_stat;
    } t_knt_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic invalid;
        logic pow_done;
        logic dig_found;
        logic has_up;
        logic has_down;
        logic fanout;
        logic peer_ok;
        logic k_end;
        logic lvl_end;
        logic out_free;
    } t_knt_sts;

    // Method code from direction, modifiers and neighbour presence
    function automatic logic [METHOD_W-1:0] pick_method(
        input logic fanout,
        input logic aggregate,
        input logic broadcast,
        input logic has_up,
        input logic has_down
    );
        logic [METHOD_W-1:0] m;
        if (!fanout) begin
            if (!has_down)
                m = METH_SEND_TERM;
            else if (aggregate)
                m = has_up ? METH_REDUCE_WP : METH_REDUCE_TERM;
            else
                m = has_up ? METH_GATHER_WP : METH_RECV_TERM;
        end else begin
            if (!has_down)
                m = METH_RECV_TERM;
            else if (broadcast)
                m = has_up ? METH_BCAST_WP : METH_SEND_TERM;
            else
                m = has_up ? METH_SCATTER_WP : METH_SCATTER_TERM;
        end
        return m;
    endfunction

endpackage

`default_nettype wire

// ===== src/knt_cfg.sv =====
// Configuration registers of the k-nomial tree neighbour finder.
// Holds the written values and presents the saturated member count and degree.
// Depends on knt_pkg.
`default_nettype none

module knt_cfg #(
    parameter int MAX_MEMBERS = knt_pkg::MAX_MEMBERS_DEF,
    parameter int MAX_DEGREE  = knt_pkg::MAX_DEGREE_DEF,
    localparam int NW  = $clog2(MAX_MEMBERS + 1),
    localparam int DGW = $clog2(MAX_DEGREE + 1)
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [knt_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [knt_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic      [NW-1:0]                  o_n,
    output logic      [knt_pkg::ROOT_W-1:0]     o_root,
    output logic      [DGW-1:0]                 o_deg,
    output logic                                o_fanout,
    output logic                                o_aggregate,
    output logic                                o_broadcast
);
    import knt_pkg::*;

    logic [COUNT_W-1:0] r_count;
    logic [ROOT_W-1:0]  r_root;
    logic [DEG_W-1:0]   r_degree;
    logic               r_fanout;
    logic               r_aggregate;
    logic               r_broadcast;

    // Take register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= COUNT_W'(1);
            r_root      <= '0;
            r_degree    <= DEG_W'(2);
            r_fanout    <= 1'b0;
            r_aggregate <= 1'b0;
            r_broadcast <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_MEMBER_COUNT: r_count     <= i_cfg_data[COUNT_W-1:0];
                REG_ROOT_INDEX:   r_root      <= i_cfg_data[ROOT_W-1:0];
                REG_DEGREE:       r_degree    <= i_cfg_data[DEG_W-1:0];
                REG_DIRECTION:    r_fanout    <= i_cfg_data[0];
                REG_AGGREGATE:    r_aggregate <= i_cfg_data[0];
                REG_BROADCAST:    r_broadcast <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Saturate member count to the tree size and degree into its legal range
    always_comb begin
        if (32'(r_count) > 32'(MAX_MEMBERS))
            o_n = NW'(MAX_MEMBERS);
        else
            o_n = NW'(r_count);

        if (r_degree < DEG_W'(2))
            o_deg = DGW'(2);
        else if (32'(r_degree) > 32'(MAX_DEGREE))
            o_deg = DGW'(MAX_DEGREE);
        else
            o_deg = DGW'(r_degree);
    end

    assign o_root      = r_root;
    assign o_fanout    = r_fanout;
    assign o_aggregate = r_aggregate;
    assign o_broadcast = r_broadcast;

endmodule

`default_nettype wire

// ===== src/knt_dp.sv =====
// Datapath of the k-nomial tree neighbour finder: rank, power table, digit
// walk, child stepping and the result register. Driven by knt_ctrl commands.
// Depends on knt_pkg.
`default_nettype none

module knt_dp #(
    parameter int MAX_MEMBERS = knt_pkg::MAX_MEMBERS_DEF,
    parameter int MAX_DEGREE  = knt_pkg::MAX_DEGREE_DEF,
    localparam int NW  = $clog2(MAX_MEMBERS + 1),
    localparam int DGW = $clog2(MAX_DEGREE + 1)
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire knt_pkg::t_knt_cmd            i_cmd,
    output knt_pkg::t_knt_sts                 o_sts,
    input  wire logic [knt_pkg::IDX_W-1:0]    i_my_index,
    input  wire logic [NW-1:0]                i_n,
    input  wire logic [knt_pkg::ROOT_W-1:0]   i_root,
    input  wire logic [DGW-1:0]               i_deg,
    input  wire logic                         i_fanout,
    input  wire logic                         i_aggregate,
    input  wire logic                         i_broadcast,
    input  wire logic                         i_out_ready,
    output logic                              o_out_valid,
    output logic [knt_pkg::IDX_W-1:0]         o_peer_index,
    output logic                              o_is_parent,
    output logic [knt_pkg::METHOD_W-1:0]      o_method,
    output logic [knt_pkg::STATUS_W-1:0]      o_status,
    output logic                              o_last
);
    import knt_pkg::*;

    localparam int RW   = $clog2(MAX_MEMBERS);
    localparam int KW   = $clog2(MAX_DEGREE);
    localparam int LVLS = $clog2(MAX_MEMBERS);
    localparam int LW   = (LVLS > 1) ? $clog2(LVLS) : 1;
    localparam int PW   = RW + DGW + 1;

    // Item state
    logic              r_invalid;
    logic [RW-1:0]     r_rank;
    logic [RW-1:0]     r_pw;
    logic [RW-1:0]     r_pow [LVLS];
    logic [LW-1:0]     r_lvl;
    logic [RW-1:0]     r_rem;
    logic [RW-1:0]     r_lvl_rem;
    logic [RW-1:0]     r_parent_rel;
    logic              r_has_up;
    logic              r_has_down;
    logic [LW-1:0]     r_top;
    logic [PW-1:0]     r_mul;
    logic [PW-1:0]     r_peer;
    logic [KW-1:0]     r_k;
    logic              r_hi_out;

    // Result register
    logic                r_out_valid;
    logic [IDX_W-1:0]    r_peer_index;
    logic                r_is_parent;
    logic [METHOD_W-1:0] r_method;
    logic [STATUS_W-1:0] r_status;
    logic                r_last;

    logic [NW:0]         rank_sum;
    logic [NW:0]         rank_c;
    logic                invalid_c;
    logic [RW+DGW-1:0]   prod;
    logic                pow_done;
    logic [RW-1:0]       p_cur;
    logic                levels_exist;
    logic [LW-1:0]       top_c;
    logic                peer_ok;
    logic                k_end;
    logic                lvl_end;
    logic                last_child;
    logic                out_free;
    logic [RW-1:0]       rel_sel;
    logic [NW:0]         abs_sum;
    logic [NW:0]         abs_c;
    logic [DGW-1:0]      deg_m1;
    logic [METHOD_W-1:0] meth;

    assign deg_m1 = i_deg - DGW'(1);
    assign p_cur  = r_pow[r_lvl];

    // Range check and root-relative rank of the incoming index
    always_comb begin
        invalid_c = (i_n == '0) || (32'(i_my_index) >= 32'(i_n)) ||
                    (32'(i_root) >= 32'(i_n));
        rank_sum  = (NW+1)'(i_my_index) + (NW+1)'(i_n) - (NW+1)'(i_root);
        if (rank_sum >= (NW+1)'(i_n))
            rank_c = rank_sum - (NW+1)'(i_n);
        else
            rank_c = rank_sum;
    end

    // Next power of the degree
    assign prod     = (RW+DGW)'(r_pw) * (RW+DGW)'(i_deg);
    assign pow_done = ((RW+DGW+1)'(prod) >= (RW+DGW+1)'(i_n)) || (r_lvl == LW'(LVLS - 1));

    // Children start below the parent's digit level, or at the top for the root
    assign levels_exist = !r_has_up || (r_lvl != '0);
    assign top_c        = r_has_up ? r_lvl - LW'(1) : r_lvl;

    // Child stepping status
    assign peer_ok = r_peer < PW'(i_n);
    assign k_end   = i_fanout ? (r_k == KW'(deg_m1)) : (r_k == KW'(1));
    assign lvl_end = i_fanout ? (r_lvl == '0) : (r_lvl == r_top);

    always_comb begin
        if (i_fanout)
            last_child = (r_lvl == '0) && (k_end || (r_peer + PW'(1) >= PW'(i_n)));
        else
            last_child = (r_k == KW'(1)) && ((r_lvl == r_top) || r_hi_out) && !r_has_up;
    end

    // Convert a relative rank back to an absolute index
    always_comb begin
        rel_sel = i_cmd.emit_par ? r_parent_rel : RW'(r_peer);
        abs_sum = (NW+1)'(rel_sel) + (NW+1)'(i_root);
        if (abs_sum >= (NW+1)'(i_n))
            abs_c = abs_sum - (NW+1)'(i_n);
        else
            abs_c = abs_sum;
    end

    assign meth     = pick_method(i_fanout, i_aggregate, i_broadcast, r_has_up, r_has_down);
    assign out_free = !r_out_valid || i_out_ready;

    // Item working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_invalid  <= invalid_c;
            r_rank     <= RW'(rank_c);
            r_pw       <= RW'(1);
            r_pow[0]   <= RW'(1);
            r_lvl      <= '0;
            r_has_up   <= 1'b0;
            r_has_down <= 1'b0;
        end

        // Build the power table up to the largest power below the member count
        if (i_cmd.pow_step) begin
            if (!pow_done) begin
                r_pow[r_lvl + LW'(1)] <= RW'(prod);
                r_pw                  <= RW'(prod);
                r_lvl                 <= r_lvl + LW'(1);
            end else begin
                r_rem     <= r_rank;
                r_lvl_rem <= r_rank;
            end
        end

        // Walk digits from the top: subtract, drop a level, or record the parent
        if (i_cmd.dig_step) begin
            if (r_rem >= p_cur) begin
                r_rem <= r_rem - p_cur;
            end else if (r_rem != '0) begin
                r_lvl     <= r_lvl - LW'(1);
                r_lvl_rem <= r_rem;
            end else if (r_rank != '0) begin
                r_has_up     <= 1'b1;
                r_parent_rel <= r_rank - r_lvl_rem;
            end
        end

        if (i_cmd.setup) begin
            r_top      <= top_c;
            r_has_down <= levels_exist && ((RW+1)'(r_rank) + (RW+1)'(1) < (RW+1)'(i_n));
            r_lvl      <= i_fanout ? top_c : '0;
        end

        if (i_cmd.lvl_mul)
            r_mul <= PW'(p_cur) * PW'(deg_m1);

        // Start a level: highest multiple for fanin, lowest for fanout
        if (i_cmd.k_init) begin
            if (i_fanout) begin
                r_peer <= PW'(r_rank) + PW'(p_cur);
                r_k    <= KW'(1);
            end else begin
                r_peer <= PW'(r_rank) + r_mul;
                r_k    <= KW'(deg_m1);
            end
            r_hi_out <= (PW'(r_rank) + r_mul + PW'(p_cur)) >= PW'(i_n);
        end

        if (i_cmd.k_step) begin
            if (i_fanout) begin
                r_peer <= r_peer + PW'(p_cur);
                r_k    <= r_k + KW'(1);
            end else begin
                r_peer <= r_peer - PW'(p_cur);
                r_k    <= r_k - KW'(1);
            end
        end

        if (i_cmd.lvl_next)
            r_lvl <= i_fanout ? r_lvl - LW'(1) : r_lvl + LW'(1);
    end

    // Result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_out_valid <= 1'b0;
        else if (i_cmd.emit_child || i_cmd.emit_par || i_cmd.emit_stat)
            r_out_valid <= 1'b1;
        else if (i_out_ready)
            r_out_valid <= 1'b0;
    end

    // Result register payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_stat) begin
            r_peer_index <= '0;
            r_is_parent  <= 1'b0;
            r_method     <= meth;
            r_status     <= r_invalid ? STS_BAD_RANGE : STS_NO_PEERS;
            r_last       <= 1'b1;
        end else if (i_cmd.emit_par) begin
            r_peer_index <= IDX_W'(abs_c);
            r_is_parent  <= 1'b1;
            r_method     <= meth;
            r_status     <= STS_PEER;
            r_last       <= !i_fanout || !r_has_down;
        end else if (i_cmd.emit_child) begin
            r_peer_index <= IDX_W'(abs_c);
            r_is_parent  <= 1'b0;
            r_method     <= meth;
            r_status     <= STS_PEER;
            r_last       <= last_child;
        end
    end

    always_comb begin
        o_sts.invalid   = r_invalid;
        o_sts.pow_done  = pow_done;
        o_sts.dig_found = (r_rem == '0);
        o_sts.has_up    = r_has_up;
        o_sts.has_down  = r_has_down;
        o_sts.fanout    = i_fanout;
        o_sts.peer_ok   = peer_ok;
        o_sts.k_end     = k_end;
        o_sts.lvl_end   = lvl_end;
        o_sts.out_free  = out_free;
    end

    assign o_out_valid  = r_out_valid;
    assign o_peer_index = r_peer_index;
    assign o_is_parent  = r_is_parent;
    assign o_method     = r_method;
    assign o_status     = r_status;
    assign o_last       = r_last;

endmodule

`default_nettype wire

// ===== src/knt_ctrl.sv =====
// Controller of the k-nomial tree neighbour finder: sequences the power build,
// digit walk and neighbour emission for one item at a time.
// Depends on knt_pkg.
`default_nettype none

module knt_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire knt_pkg::t_knt_sts i_sts,
    output knt_pkg::t_knt_cmd      o_cmd
);
    import knt_pkg::*;

    t_knt_state r_state;
    t_knt_state n_state;
    logic       child_go;

    // A child step proceeds unless a valid peer waits for the result register
    assign child_go = !i_sts.peer_ok || i_sts.out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_state <= ST_IDLE;
        else
            r_state <= n_state;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:
                if (i_in_valid)
                    n_state = ST_POW;
            ST_POW:
                if (i_sts.invalid)
                    n_state = ST_STATUS;
                else if (i_sts.pow_done)
                    n_state = ST_DIG;
            ST_DIG:
                if (i_sts.dig_found)
                    n_state = ST_SETUP;
            ST_SETUP:
                n_state = ST_ROUTE;
            ST_ROUTE:
                if (!i_sts.has_up && !i_sts.has_down)
                    n_state = ST_STATUS;
                else if (!i_sts.fanout)
                    n_state = i_sts.has_down ? ST_LVL_MUL : ST_PARENT;
                else
                    n_state = i_sts.has_up ? ST_PARENT : ST_LVL_MUL;
            ST_LVL_MUL:
                n_state = ST_K_INIT;
            ST_K_INIT:
                n_state = ST_CHILD;
            ST_CHILD:
                if (child_go && i_sts.k_end) begin
                    if (!i_sts.lvl_end)
                        n_state = ST_LVL_MUL;
                    else if (!i_sts.fanout && i_sts.has_up)
                        n_state = ST_PARENT;
                    else
                        n_state = ST_IDLE;
                end
            ST_PARENT:
                if (i_sts.out_free)
                    n_state = (i_sts.fanout && i_sts.has_down) ? ST_LVL_MUL : ST_IDLE;
            ST_STATUS:
                if (i_sts.out_free)
                    n_state = ST_IDLE;
            default:
                n_state = ST_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_POW:
                o_cmd.pow_step = !i_sts.invalid;
            ST_DIG:
                o_cmd.dig_step = 1'b1;
            ST_SETUP:
                o_cmd.setup = 1'b1;
            ST_LVL_MUL:
                o_cmd.lvl_mul = 1'b1;
            ST_K_INIT:
                o_cmd.k_init = 1'b1;
            ST_CHILD:
                if (child_go) begin
                    o_cmd.emit_child = i_sts.peer_ok;
                    o_cmd.k_step     = !i_sts.k_end;
                    o_cmd.lvl_next   = i_sts.k_end && !i_sts.lvl_end;
                end
            ST_PARENT:
                o_cmd.emit_par = i_sts.out_free;
            ST_STATUS:
                o_cmd.emit_stat = i_sts.out_free;
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// ===== src/knomial_tree_neighbors.sv =====
// Top level of the k-nomial tree neighbour finder.
// Instantiates knt_cfg, knt_ctrl and knt_dp; depends on knt_pkg.
//
//   channel   direction  handshake                  payload
//   config    in         i_cfg_we                   i_cfg_index, i_cfg_data
//   query     in         i_in_valid / o_in_ready    i_my_index
//   neighbour out        o_out_valid / i_out_ready  o_peer_index, o_is_parent,
//                                                   o_method, o_status, o_last
//
// One query at a time. A query builds the power table of the degree (powers below the
// member count), walks the digits of its rank and routes, then for each child level forms
// the top multiple, starts the level and steps through its children; a parent or status
// result is emitted from a state of its own.
// Reset is synchronous and active low; it sets config, state and output valid only.
// A full result register stalls emission; the next query is taken once the last
// result of the current one sits in that register.
`default_nettype none

module knomial_tree_neighbors #(
    parameter int MAX_MEMBERS = knt_pkg::MAX_MEMBERS_DEF,
    parameter int MAX_DEGREE  = knt_pkg::MAX_DEGREE_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [knt_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [knt_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic [knt_pkg::IDX_W-1:0]      i_my_index,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic      [knt_pkg::IDX_W-1:0]      o_peer_index,
    output logic                                o_is_parent,
    output logic      [knt_pkg::METHOD_W-1:0]   o_method,
    output logic      [knt_pkg::STATUS_W-1:0]   o_status,
    output logic                                o_last
);
    import knt_pkg::*;

    localparam int NW  = $clog2(MAX_MEMBERS + 1);
    localparam int DGW = $clog2(MAX_DEGREE + 1);

    logic [NW-1:0]     cfg_n;
    logic [ROOT_W-1:0] cfg_root;
    logic [DGW-1:0]    cfg_deg;
    logic              cfg_fanout;
    logic              cfg_aggregate;
    logic              cfg_broadcast;
    t_knt_cmd          cmd;
    t_knt_sts          sts;

    // Configuration registers
    knt_cfg #(
        .MAX_MEMBERS (MAX_MEMBERS),
        .MAX_DEGREE  (MAX_DEGREE)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_n         (cfg_n),
        .o_root      (cfg_root),
        .o_deg       (cfg_deg),
        .o_fanout    (cfg_fanout),
        .o_aggregate (cfg_aggregate),
        .o_broadcast (cfg_broadcast)
    );

    // Sequencer
    knt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Arithmetic and result register
    knt_dp #(
        .MAX_MEMBERS (MAX_MEMBERS),
        .MAX_DEGREE  (MAX_DEGREE)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_my_index   (i_my_index),
        .i_n          (cfg_n),
        .i_root       (cfg_root),
        .i_deg        (cfg_deg),
        .i_fanout     (cfg_fanout),
        .i_aggregate  (cfg_aggregate),
        .i_broadcast  (cfg_broadcast),
        .i_out_ready  (i_out_ready),
        .o_out_valid  (o_out_valid),
        .o_peer_index (o_peer_index),
        .o_is_parent  (o_is_parent),
        .o_method     (o_method),
        .o_status     (o_status),
        .o_last       (o_last)
    );

endmodule

`default_nettype wire
